[src/deu_pkg.sv]
// Shared types and constants of the digitizer event unpacker.
`timescale 1ns / 1ps
`default_nettype none
package deu_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_SAMPLE         = 3'd0,
    ST_BAD_MARKER     = 3'd1,
    ST_COUNT_MISMATCH = 3'd2,
    ST_EVENT_MISMATCH = 3'd3,
    ST_BAD_CHANNEL    = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BLOCK_WORDS    = 2'd0,
    CFG_BOARD_ID       = 2'd1,
    CFG_EXPECTED_EVENT = 2'd2
  } cfg_index_t;

  localparam logic [3:0] EVENT_MARKER   = 4'hA;
  localparam logic [3:0] CHANNEL_MARKER = 4'h8;

  // Fixed word positions inside the event block
  localparam logic [27:0] POS_HEADER  = 28'd0;
  localparam logic [27:0] POS_COUNTER = 28'd3;
  localparam logic [27:0] POS_FIRST_CHANNEL = 28'd5;

  // Command handed from the parser to the output stage
  typedef struct packed {
    status_t     status;
    logic [15:0] group_tag;
    logic [15:0] channel_tag;
    logic [1:0]  rate_code;
    logic [25:0] sample_index;
    logic [15:0] sample_value;
  } cmd_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[src/deu_front.sv]
// Front parser: tracks block position and channel headers, emits commands.
`timescale 1ns / 1ps
`default_nettype none
module deu_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [31:0]  data_word,
  input  wire logic [27:0]  block_words,
  input  wire logic [31:0]  expected_event,
  output logic              push,
  output deu_pkg::cmd_t     cmd
);
  import deu_pkg::*;

  logic [27:0] word_position, word_position_next;
  logic        in_samples, in_samples_next;
  logic [25:0] words_left, words_left_next;
  logic [25:0] samples_done, samples_done_next;
  logic [15:0] current_group, current_group_next;
  logic [15:0] current_channel, current_channel_next;
  logic [1:0]  current_rate, current_rate_next;
  logic        skip_rest, skip_rest_next;

  logic [27:0] pos_inc;
  logic [25:0] chan_len;
  logic [31:0] counter_inc;
  logic        emit;
  status_t     emit_status;

  // Classify the word and compute the next parser state
  always_comb begin
    pos_inc              = word_position + 28'd1;
    chan_len             = data_word[25:0];
    counter_inc          = data_word + 32'd1;
    word_position_next   = (pos_inc == block_words) ? '0 : pos_inc;
    in_samples_next      = in_samples;
    words_left_next      = words_left;
    samples_done_next    = samples_done;
    current_group_next   = current_group;
    current_channel_next = current_channel;
    current_rate_next    = current_rate;
    skip_rest_next       = skip_rest;
    emit                 = 1'b0;
    emit_status          = ST_SAMPLE;

    if (word_position == POS_HEADER) begin
      in_samples_next   = 1'b0;
      words_left_next   = '0;
      samples_done_next = '0;
      skip_rest_next    = 1'b0;
      if (data_word[31:28] != EVENT_MARKER) begin
        emit        = 1'b1;
        emit_status = ST_BAD_MARKER;
      end else if (data_word[27:0] != block_words) begin
        emit        = 1'b1;
        emit_status = ST_COUNT_MISMATCH;
      end
    end else if (word_position == POS_COUNTER) begin
      if (counter_inc != expected_event) begin
        emit        = 1'b1;
        emit_status = ST_EVENT_MISMATCH;
      end
    end else if (word_position < POS_FIRST_CHANNEL || skip_rest) begin
      emit = 1'b0;
    end else if (!in_samples) begin
      if (words_left == '0) begin
        // first channel header word: marker, rate, length
        current_rate_next = data_word[27:26];
        if (data_word[31:28] != CHANNEL_MARKER || chan_len < 26'd2) begin
          skip_rest_next = 1'b1;
          emit           = 1'b1;
          emit_status    = ST_BAD_CHANNEL;
        end else begin
          samples_done_next = '0;
          words_left_next   = chan_len - 26'd1;
        end
      end else begin
        // second channel header word: group and channel
        current_group_next   = data_word[31:16];
        current_channel_next = data_word[15:0];
        words_left_next      = words_left - 26'd1;
        in_samples_next      = (words_left != 26'd1);
      end
    end else begin
      // sample word
      emit              = 1'b1;
      emit_status       = ST_SAMPLE;
      if (words_left == 26'd1) in_samples_next = 1'b0;
      words_left_next   = words_left - 26'd1;
      samples_done_next = samples_done + 26'd1;
    end
  end

  assign push             = accept && emit;
  assign cmd.status       = emit_status;
  assign cmd.group_tag    = current_group;
  assign cmd.channel_tag  = current_channel;
  assign cmd.rate_code    = current_rate;
  assign cmd.sample_index = samples_done;
  assign cmd.sample_value = data_word[15:0];

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position   <= '0;
      in_samples      <= 1'b0;
      words_left      <= '0;
      samples_done    <= '0;
      current_group   <= '0;
      current_channel <= '0;
      current_rate    <= '0;
      skip_rest       <= 1'b0;
    end else if (accept) begin
      word_position   <= word_position_next;
      in_samples      <= in_samples_next;
      words_left      <= words_left_next;
      samples_done    <= samples_done_next;
      current_group   <= current_group_next;
      current_channel <= current_channel_next;
      current_rate    <= current_rate_next;
      skip_rest       <= skip_rest_next;
    end
  end

endmodule
`default_nettype wire

[src/deu_queue.sv]
// Command queue between the parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module deu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire deu_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output deu_pkg::cmd_t      pop_cmd,
  output deu_pkg::q_stat_t   stat
);
  import deu_pkg::*;

  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  cmd_t               mem [DEPTH];
  logic [ADDR_W-1:0]  wr_ptr;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [COUNT_W-1:0] count;

  // Pointers wrap at DEPTH
  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  assign pop_cmd    = mem[rd_ptr];
  assign stat.full  = (count == COUNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + COUNT_W'(1);
      else if (pop && !push) count <= count - COUNT_W'(1);
    end
  end

endmodule
`default_nettype wire

[src/deu_back.sv]
// Output stage: expands commands into result words and holds them under stall.
`timescale 1ns / 1ps
`default_nettype none
module deu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire deu_pkg::cmd_t cmd,
  input  wire logic [31:0]   board_id,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         status,
  output logic [31:0]        board_tag,
  output logic [15:0]        group_tag,
  output logic [15:0]        channel_tag,
  output logic [1:0]         rate_code,
  output logic [25:0]        sample_index,
  output logic [15:0]        sample_value
);
  import deu_pkg::*;

  logic is_sample;

  assign pop       = cmd_valid && (!out_valid || !out_stall);
  assign is_sample = (cmd.status == ST_SAMPLE);

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= cmd_valid;
    end
  end

  // Result word; error words carry only status and board tag
  always_ff @(posedge clk) begin
    if (pop) begin
      status       <= cmd.status;
      board_tag    <= board_id;
      group_tag    <= is_sample ? cmd.group_tag    : '0;
      channel_tag  <= is_sample ? cmd.channel_tag  : '0;
      rate_code    <= is_sample ? cmd.rate_code    : '0;
      sample_index <= is_sample ? cmd.sample_index : '0;
      sample_value <= is_sample ? cmd.sample_value : '0;
    end
  end

endmodule
`default_nettype wire

[src/digitizer_event_unpacker_unit.sv]
// Top level of the digitizer event unpacker.
//
// Input channel: one 32-bit raw word of a digitizer event block per accepted
// word (in_valid high, in_stall low). Output channel: one result word with
// status and tags (out_valid high, out_stall low). Sample words give a tagged
// sample; header checks and bad channel headers give a status word; other
// words give nothing.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// block_words, board_id or expected_event; cfg_ready is always high.
// Throughput: one word per cycle while in_stall is low. The parser registers
// its state each word and pushes into a QUEUE_DEPTH command queue; a result
// passes through the queue storage and the output register.
// When the receiver stalls, the output register holds its word, the queue
// fills, and in_stall rises once the queue is full.
// Reset clears the block position, channel parsing state, the queue and the
// configuration registers; the next word is taken as word 0 of a block.
`timescale 1ns / 1ps
`default_nettype none
module digitizer_event_unpacker_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [31:0]  data_word,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        status,
  output logic [31:0]       board_tag,
  output logic [15:0]       group_tag,
  output logic [15:0]       channel_tag,
  output logic [1:0]        rate_code,
  output logic [25:0]       sample_index,
  output logic [15:0]       sample_value
);
  import deu_pkg::*;

  logic [27:0] block_words;
  logic [31:0] board_id;
  logic [31:0] expected_event;

  logic    in_accept;
  logic    q_push;
  logic    q_pop;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  q_stat_t q_stat;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_words    <= '0;
      board_id       <= '0;
      expected_event <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCK_WORDS:    block_words    <= cfg_data[27:0];
        CFG_BOARD_ID:       board_id       <= cfg_data;
        CFG_EXPECTED_EVENT: expected_event <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;

  deu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .data_word      (data_word),
    .block_words    (block_words),
    .expected_event (expected_event),
    .push           (q_push),
    .cmd            (push_cmd)
  );

  deu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  deu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!q_stat.empty),
    .cmd          (pop_cmd),
    .board_id     (board_id),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .board_tag    (board_tag),
    .group_tag    (group_tag),
    .channel_tag  (channel_tag),
    .rate_code    (rate_code),
    .sample_index (sample_index),
    .sample_value (sample_value)
  );

`ifndef NO_ASSERTIONS
  // No command is pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // Output stage only takes a command that exists
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // Status words carry no channel tags
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_SAMPLE) |->
      (group_tag == '0 && channel_tag == '0 && rate_code == '0 &&
       sample_index == '0 && sample_value == '0))
    else $error("status word carries channel tags");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the digitizer event unpacker top level.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import deu_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 1850;
  localparam int PLAN_ROWS    = 33;

  // How a row of the directed plan is applied and checked
  typedef enum logic [1:0] {
    ROW_CFG,     // register write
    ROW_WORD,    // word, result from the predictor
    ROW_QUIET,   // word, no result expected
    ROW_STATUS   // word, status result typed in the row
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_index_t  reg_sel;
    logic [31:0] value;
    status_t     code;
  } plan_row_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] board_tag;
    logic [15:0] group_tag;
    logic [15:0] channel_tag;
    logic [1:0]  rate_code;
    logic [25:0] sample_index;
    logic [15:0] sample_value;
  } result_t;

  // Directed plan: header checks at the register extremes, then one clean block
  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    '{ROW_STATUS, CFG_BLOCK_WORDS,    32'h0FFF_FFFF, ST_BAD_MARKER},
    '{ROW_CFG,    CFG_BLOCK_WORDS,    32'h0000_0002, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'hFFFF_FFFF, ST_SAMPLE},
    '{ROW_CFG,    CFG_BOARD_ID,       32'hFFFF_FFFF, ST_SAMPLE},
    '{ROW_CFG,    CFG_EXPECTED_EVENT, 32'hFFFF_FFFF, ST_SAMPLE},
    '{ROW_CFG,    CFG_BLOCK_WORDS,    32'h0FFF_FFFF, ST_SAMPLE},
    '{ROW_STATUS, CFG_BLOCK_WORDS,    32'hA000_0000, ST_COUNT_MISMATCH},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h0000_0000, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'hFFFF_FFFF, ST_SAMPLE},
    '{ROW_STATUS, CFG_BLOCK_WORDS,    32'h0000_0000, ST_EVENT_MISMATCH},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h0000_0000, ST_SAMPLE},
    '{ROW_CFG,    CFG_BLOCK_WORDS,    32'h0000_0007, ST_SAMPLE},
    '{ROW_STATUS, CFG_BLOCK_WORDS,    32'h8000_0001, ST_BAD_CHANNEL},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h8C00_0004, ST_SAMPLE},
    '{ROW_CFG,    CFG_BLOCK_WORDS,    32'h0000_0010, ST_SAMPLE},
    '{ROW_CFG,    CFG_EXPECTED_EVENT, 32'h0000_0000, ST_SAMPLE},
    '{ROW_CFG,    CFG_BOARD_ID,       32'h1357_9BDF, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'hA000_0010, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'hFFFF_FFFF, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h0000_0000, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'hFFFF_FFFF, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h0000_0000, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h8C00_0004, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'hFFFF_0000, ST_SAMPLE},
    '{ROW_WORD,   CFG_BLOCK_WORDS,    32'hFFFF_FFFF, ST_SAMPLE},
    '{ROW_WORD,   CFG_BLOCK_WORDS,    32'h0000_0000, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h8000_0002, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h0000_FFFF, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h87FF_FFFF, ST_SAMPLE},
    '{ROW_QUIET,  CFG_BLOCK_WORDS,    32'h0001_0002, ST_SAMPLE},
    '{ROW_WORD,   CFG_BLOCK_WORDS,    32'hABCD_1234, ST_SAMPLE},
    '{ROW_WORD,   CFG_BLOCK_WORDS,    32'h5555_AAAA, ST_SAMPLE},
    '{ROW_WORD,   CFG_BLOCK_WORDS,    32'hAAAA_5555, ST_SAMPLE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] data_word = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_BLOCK_WORDS;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] board_tag;
  logic [15:0] group_tag;
  logic [15:0] channel_tag;
  logic [1:0]  rate_code;
  logic [25:0] sample_index;
  logic [15:0] sample_value;

  digitizer_event_unpacker_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_word(data_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .board_tag(board_tag), .group_tag(group_tag), .channel_tag(channel_tag),
    .rate_code(rate_code), .sample_index(sample_index), .sample_value(sample_value)
  );

  always #5 clk = ~clk;

  // Register copies and parser state of the predictor
  logic [27:0] blk_words_reg = '0;
  logic [31:0] board_id_reg = '0;
  logic [31:0] event_reg = '0;
  logic [27:0] word_pos = '0;
  logic        in_samples = 1'b0;
  logic        skip_rest = 1'b0;
  logic [25:0] words_left = '0;
  logic [25:0] samples_done = '0;
  logic [15:0] cur_group = '0;
  logic [15:0] cur_channel = '0;
  logic [1:0]  cur_rate = '0;

  result_t pending_results [$];
  int      mismatches = 0;
  int      cycles = 0;
  int      random_words = 0;
  int      hold_left = 0;
  int      stall_left = 0;
  bit      idle_in = 1'b1;
  bit      idle_out = 1'b1;

  // Parse one word of the stream; returns 1 when it yields a result word
  function automatic bit unpack_word(input logic [31:0] w, output result_t r);
    logic [27:0] at;
    logic [27:0] nxt;
    logic [25:0] len;
    at = word_pos;
    nxt = at + 28'd1;
    r = '0;
    r.status = ST_SAMPLE;
    r.board_tag = board_id_reg;
    word_pos = (nxt == blk_words_reg) ? 28'd0 : nxt;

    // event header: fresh channel parsing, marker takes precedence over count
    if (at == POS_HEADER) begin
      in_samples = 1'b0;
      words_left = '0;
      samples_done = '0;
      skip_rest = 1'b0;
      if (w[31:28] != EVENT_MARKER) begin
        r.status = ST_BAD_MARKER;
        return 1'b1;
      end
      if (w[27:0] != blk_words_reg) begin
        r.status = ST_COUNT_MISMATCH;
        return 1'b1;
      end
      return 1'b0;
    end
    if (at == POS_COUNTER) begin
      if (w + 32'd1 != event_reg) begin
        r.status = ST_EVENT_MISMATCH;
        return 1'b1;
      end
      return 1'b0;
    end
    if (at < POS_FIRST_CHANNEL || skip_rest) return 1'b0;

    // channel header words
    if (!in_samples) begin
      if (words_left == 26'd0) begin
        len = w[25:0];
        cur_rate = w[27:26];
        if (w[31:28] != CHANNEL_MARKER || len < 26'd2) begin
          skip_rest = 1'b1;
          r.status = ST_BAD_CHANNEL;
          return 1'b1;
        end
        samples_done = '0;
        words_left = len - 26'd1;
      end else begin
        cur_group = w[31:16];
        cur_channel = w[15:0];
        words_left = words_left - 26'd1;
        in_samples = (words_left != 26'd0);
      end
      return 1'b0;
    end

    // sample word
    r.group_tag = cur_group;
    r.channel_tag = cur_channel;
    r.rate_code = cur_rate;
    r.sample_index = samples_done;
    r.sample_value = w[15:0];
    if (words_left == 26'd1) in_samples = 1'b0;
    words_left = words_left - 26'd1;
    samples_done = samples_done + 26'd1;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Result side: compare each accepted word, then draw the next stall
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, status 0x%0h", $time, status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("board_tag", want.board_tag, board_tag);
        check_field("group_tag", 32'(want.group_tag), 32'(group_tag));
        check_field("channel_tag", 32'(want.channel_tag), 32'(channel_tag));
        check_field("rate_code", 32'(want.rate_code), 32'(rate_code));
        check_field("sample_index", 32'(want.sample_index), 32'(sample_index));
        check_field("sample_value", 32'(want.sample_value), 32'(sample_value));
      end
      stall_left = idle_out ? $urandom_range(0, 14) : 0;
    end
  end

  // Stall driver: a long hold when asked, else the drawn per-word stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("** digitizer_event_unpacker_unit: FAILED **");
    $finish;
  end

  // Offer one word after a drawn gap; predict it once accepted
  task automatic send_word(input logic [31:0] w, input row_kind_t how,
                           input status_t code);
    int gap;
    bit has;
    result_t r;
    gap = idle_in ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = unpack_word(w, r);
    if (how == ROW_WORD && has) begin
      pending_results.insert(pending_results.size(), r);
    end else if (how == ROW_STATUS) begin
      r = '0;
      r.status = code;
      r.board_tag = board_id_reg;
      pending_results.insert(pending_results.size(), r);
    end
  endtask

  // Wait until the block has delivered everything and gone quiet
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t sel, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      CFG_BLOCK_WORDS:    blk_words_reg = value[27:0];
      CFG_BOARD_ID:       board_id_reg = value;
      CFG_EXPECTED_EVENT: event_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One event block of exactly blk_words_reg words: mostly well formed,
  // some with a single broken field, some pure noise
  task automatic send_block(input bit clean);
    logic [31:0] blk [$];
    int          heads [$];
    int          kind;
    int          len;
    int          n;
    int          h;
    logic [31:0] w;
    logic [1:0]  rate;
    kind = clean ? 9 : $urandom_range(0, 9);
    blk.insert(blk.size(), {EVENT_MARKER, blk_words_reg});
    blk.insert(blk.size(), $urandom);
    blk.insert(blk.size(), $urandom);
    blk.insert(blk.size(), event_reg - 32'd1);
    blk.insert(blk.size(), $urandom);
    while (blk.size() < blk_words_reg) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 32'h3FF_FFFF)
                                         : $urandom_range(2, 12);
      rate = 2'($urandom_range(0, 3));
      heads.insert(heads.size(), blk.size());
      blk.insert(blk.size(), {CHANNEL_MARKER, rate, 26'(len)});
      blk.insert(blk.size(), $urandom);
      for (n = 2; n < len && blk.size() < blk_words_reg; n++)
        blk.insert(blk.size(), $urandom);
    end
    while (blk.size() > blk_words_reg) blk.pop_back();

    if (kind == 0) begin
      foreach (blk[i]) blk[i] = $urandom;
    end else if (kind <= 2) begin
      case ($urandom_range(0, 4))
        0: begin
          w = blk[0];
          w[31:28] = EVENT_MARKER ^ 4'($urandom_range(1, 15));
          blk[0] = w;
        end
        1: begin
          w = blk[0];
          w[27:0] = w[27:0] ^ (28'($urandom) | 28'd1);
          blk[0] = w;
        end
        2: if (blk.size() > 3) blk[3] = $urandom;
        3: if (heads.size() > 0) begin
          h = heads[$urandom_range(0, heads.size() - 1)];
          w = blk[h];
          w[31:28] = CHANNEL_MARKER ^ 4'($urandom_range(1, 15));
          blk[h] = w;
        end
        default: if (heads.size() > 0) begin
          h = heads[$urandom_range(0, heads.size() - 1)];
          w = blk[h];
          w[25:0] = 26'($urandom_range(0, 1));
          blk[h] = w;
        end
      endcase
    end

    foreach (blk[i]) begin
      send_word(blk[i], ROW_WORD, ST_SAMPLE);
      random_words++;
    end
  endtask

  initial begin
    int i;
    int phase;
    int nblk;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed plan
    for (i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(PLAN[i].reg_sel, PLAN[i].value);
      end else begin
        send_word(PLAN[i].value, PLAN[i].kind, PLAN[i].code);
      end
    end

    // random phases, whole blocks each, new settings between phases
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      quiesce();
      if (phase == 0) begin
        write_reg(CFG_BLOCK_WORDS, 32'd40);
      end else begin
        case ($urandom_range(0, 9))
          0: write_reg(CFG_BLOCK_WORDS, $urandom_range(1, 4));
          1: write_reg(CFG_BLOCK_WORDS, $urandom_range(5, 6));
          default: write_reg(CFG_BLOCK_WORDS, $urandom_range(7, 40));
        endcase
      end
      write_reg(CFG_BOARD_ID, pick_word());
      write_reg(CFG_EXPECTED_EVENT, pick_word());

      if (phase == 0) begin
        // receiver holds off while the sender keeps offering words
        idle_in = 1'b0;
        idle_out = 1'b1;
        hold_left = 250;
        for (nblk = 0; nblk < 4; nblk++) send_block(1'b1);
      end else begin
        idle_in = ($urandom_range(0, 3) != 0);
        idle_out = ($urandom_range(0, 3) != 0);
        nblk = $urandom_range(3, 8);
        repeat (nblk) send_block(1'b0);
      end
      phase++;
    end

    // drain and let the pipeline run dry
    quiesce();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      $display("%0d expected result words never arrived", pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** digitizer_event_unpacker_unit: PASSED **");
    end else begin
      $display("** digitizer_event_unpacker_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
src/deu_pkg.sv
src/deu_front.sv
src/deu_queue.sv
src/deu_back.sv
src/digitizer_event_unpacker_unit.sv
bench/tb.sv
